### src/mbcs_pkg.sv
// shared types, constants and state codes for the mesh bounds and sphere unit
package mbcs_pkg;

  localparam int COORD_W          = 24;
  localparam int HALF_W           = 23;
  localparam int RAD_W            = 25;
  localparam int DIST_W           = 50;
  localparam int ROOT_W           = 25;
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int VTX_W            = 3 * COORD_W;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    logic   last;
  } in_t;

  typedef struct packed {
    coord_t            center_x;
    coord_t            center_y;
    coord_t            center_z;
    logic [HALF_W-1:0] half_x;
    logic [HALF_W-1:0] half_y;
    logic [HALF_W-1:0] half_z;
    logic [RAD_W-1:0]  radius;
    logic              overflow;
  } out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SCAN,
    ST_SQRT_GO,
    ST_SQRT_WAIT
  } state_t;

endpackage

### src/mbcs_store.sv
// vertex memory: one write port, one read port, registered read data
module mbcs_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 72
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/mbcs_div.sv
// serial signed divider, one quotient bit per cycle, truncates toward zero
module mbcs_div #(
  parameter int SUM_W = 35,
  parameter int CNT_W = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]       divisor,
  output logic                   done,
  output mbcs_pkg::coord_t       quotient
);
  import mbcs_pkg::*;

  localparam int IT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [IT_W-1:0]  it_r, it_nxt;
  logic             run_r, run_nxt;
  logic             neg_r, neg_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W:0]   sh;
  logic [CNT_W:0]   dv;
  logic [SUM_W-1:0] signed_q;

  // one restoring step per cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    it_nxt   = it_r;
    run_nxt  = run_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    sh       = {rem_r, quo_r[SUM_W-1]};
    dv       = {1'b0, divisor};
    if (start) begin
      neg_nxt = dividend[SUM_W-1];
      quo_nxt = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem_nxt = '0;
      it_nxt  = IT_W'(SUM_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (sh >= dv) begin
        rem_nxt = CNT_W'(sh - dv);
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[CNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      it_nxt = it_r - 1'b1;
      if (it_r == IT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      it_r   <= it_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  // apply the sign of the dividend
  assign signed_q = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient = signed_q[COORD_W-1:0];
  assign done     = done_r;

endmodule

### src/mbcs_sqrt.sv
// serial integer square root, one result bit per cycle
module mbcs_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [mbcs_pkg::DIST_W-1:0]     value,
  output logic                            done,
  output logic [mbcs_pkg::ROOT_W-1:0]     root
);
  import mbcs_pkg::*;

  localparam int REM_W = ROOT_W + 3;
  localparam int IT_W  = $clog2(ROOT_W + 1);

  logic [DIST_W-1:0] n_r, n_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [IT_W-1:0]   it_r, it_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  sh;
  logic [REM_W-1:0]  trial;

  // two radicand bits per step
  always_comb begin
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    it_nxt   = it_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    sh       = {rem_r[REM_W-3:0], n_r[DIST_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    if (start) begin
      n_nxt    = value;
      rem_nxt  = '0;
      root_nxt = '0;
      it_nxt   = IT_W'(ROOT_W);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      n_nxt = {n_r[DIST_W-3:0], 2'b00};
      if (sh >= trial) begin
        rem_nxt  = sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      it_nxt = it_r - 1'b1;
      if (it_r == IT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      it_r   <= it_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root = root_r;
  assign done = done_r;

endmodule

### src/mesh_bounds_centroid_sphere_unit.sv
// top level: vertex intake, accumulators, radius scan and result register
//
//   channel   ports                    direction   transfer when
//   input     start, busy, in_data     in          start high and busy low
//   result    out_valid, out_data      out         out_valid high (one cycle)
//
// Vertices are taken back to back; while there is room, each is written to
// the vertex memory and folded into sums, minima and maxima, and past that it
// is dropped and flagged. A vertex marked last starts the finish: three serial
// divisions, a scan over the memory's single read port, then a serial square
// root. busy stays high from the last vertex until the result cycle. Reset
// clears all control and accumulator state; the memory needs no clearing pass.
// The receiver cannot stall the result.
module mesh_bounds_centroid_sphere_unit #(
  parameter int MAX_VERTICES = mbcs_pkg::MAX_VERTICES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mbcs_pkg::in_t  in_data,
  output logic           out_valid,
  output mbcs_pkg::out_t out_data
);
  import mbcs_pkg::*;

  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int SUM_W  = COORD_W + CNT_W;
  localparam int SQ_W   = 2 * COORD_W;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]        count_r;
  logic signed [SUM_W-1:0] sum_r [3];
  coord_t                  min_r [3];
  coord_t                  max_r [3];
  coord_t                  ctr_r [3];
  logic                    dropped_r;
  logic [1:0]              axis_r;
  logic [CNT_W-1:0]        idx_r;
  logic                    v0_r, v1_r;
  logic [SQ_W-1:0]         sq_r [3];
  logic [DIST_W-1:0]       best_r;
  logic                    out_valid_r;
  out_t                    out_r;

  logic                    accept;
  logic                    room;
  logic                    finish;
  logic                    div_start, div_done;
  coord_t                  div_q;
  logic                    sq_start, sq_done;
  logic [ROOT_W-1:0]       root;
  logic                    rd_en;
  logic [VTX_W-1:0]        rd_data;
  coord_t                  vtx [3];
  coord_t                  rv  [3];
  logic [DIST_W-1:0]       dist_sum;

  assign accept = start && !busy;
  assign room   = count_r < CNT_W'(MAX_VERTICES);
  assign finish = (state_r == ST_SQRT_WAIT) && sq_done;
  assign vtx[0] = in_data.pos_x;
  assign vtx[1] = in_data.pos_y;
  assign vtx[2] = in_data.pos_z;

  // next state
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    sq_start  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (accept && in_data.last) begin
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = (axis_r == 2'd2) ? ST_SCAN : ST_DIV_GO;
        end
      end
      ST_SCAN: begin
        if (idx_r == count_r && !v0_r && !v1_r) begin
          state_nxt = ST_SQRT_GO;
        end
      end
      ST_SQRT_GO: begin
        sq_start  = 1'b1;
        state_nxt = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (sq_done) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_LOAD);

  // accumulators: fold each stored vertex, clear after the result
  always_ff @(posedge clk) begin
    if (!rst_n || finish) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        sum_r[k] <= '0;
        min_r[k] <= '0;
        max_r[k] <= '0;
      end
    end else if (accept) begin
      if (room) begin
        count_r <= count_r + 1'b1;
        for (int k = 0; k < 3; k++) begin
          sum_r[k] <= sum_r[k] + SUM_W'(vtx[k]);
          if (count_r == '0 || vtx[k] < min_r[k]) begin
            min_r[k] <= vtx[k];
          end
          if (count_r == '0 || vtx[k] > max_r[k]) begin
            max_r[k] <= vtx[k];
          end
        end
      end else begin
        dropped_r <= 1'b1;
      end
    end
  end

  // vertex memory
  mbcs_store #(
    .DEPTH  (MAX_VERTICES),
    .ADDR_W (ADDR_W),
    .DATA_W (VTX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && room),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data ({in_data.pos_z, in_data.pos_y, in_data.pos_x}),
    .rd_en   (rd_en),
    .rd_addr (idx_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // centroid, one axis after another
  mbcs_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r[axis_r]),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= '0;
    end else if (state_r == ST_LOAD) begin
      axis_r <= '0;
    end else if (state_r == ST_DIV_WAIT && div_done) begin
      axis_r <= axis_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV_WAIT && div_done) begin
      ctr_r[axis_r] <= div_q;
    end
  end

  // radius scan: read, square, then sum and compare
  assign rd_en    = (state_r == ST_SCAN) && (idx_r != count_r);
  assign rv[0]    = rd_data[COORD_W-1:0];
  assign rv[1]    = rd_data[2*COORD_W-1:COORD_W];
  assign rv[2]    = rd_data[3*COORD_W-1:2*COORD_W];
  assign dist_sum = DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
    end else begin
      v0_r <= rd_en;
      v1_r <= v0_r;
      if (state_r != ST_SCAN) begin
        idx_r <= '0;
      end else if (rd_en) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v0_r) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [COORD_W:0] diff;
        logic [COORD_W-1:0]      mag;
        diff     = (COORD_W+1)'(rv[k]) - (COORD_W+1)'(ctr_r[k]);
        mag      = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
        sq_r[k] <= mag * mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV_GO) begin
      best_r <= '0;
    end else if (v1_r && dist_sum > best_r) begin
      best_r <= dist_sum;
    end
  end

  // radius
  mbcs_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (best_r),
    .done  (sq_done),
    .root  (root)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      logic [COORD_W:0] ext [3];
      for (int k = 0; k < 3; k++) begin
        ext[k] = (COORD_W+1)'(max_r[k]) - (COORD_W+1)'(min_r[k]);
      end
      out_r.center_x <= ctr_r[0];
      out_r.center_y <= ctr_r[1];
      out_r.center_z <= ctr_r[2];
      out_r.half_x   <= ext[0][HALF_W:1];
      out_r.half_y   <= ext[1][HALF_W:1];
      out_r.half_z   <= ext[2][HALF_W:1];
      out_r.radius   <= RAD_W'(root);
      out_r.overflow <= dropped_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count past capacity");

  a_result_after_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_SQRT_WAIT))
    else $error("result without a finished square root");

  a_cleared_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (count_r == '0 && !dropped_r && !busy))
    else $error("accumulators not cleared after the result");

endmodule

### dv/tb_top.sv
// testbench for the mesh bounds, centroid and bounding-sphere unit
module tb_top;
  import mbcs_pkg::*;

  localparam int CAPACITY   = MAX_VERTICES_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic signed [COORD_W-1:0] COORD_MIN = -(1 <<< (COORD_W - 1));
  localparam logic signed [COORD_W-1:0] COORD_MAX = (1 <<< (COORD_W - 1)) - 1;

  // running mesh model and queue of expected bounds results
  class bounds_scoreboard;
    int          px[$];
    int          py[$];
    int          pz[$];
    longint      sum[3];
    int          lo[3];
    int          hi[3];
    bit          dropped;
    out_t        expected_q[$];
    int          mismatches;

    function new();
      clear_mesh();
      mismatches = 0;
    endfunction

    function void clear_mesh();
      px.delete();
      py.delete();
      pz.delete();
      for (int k = 0; k < 3; k++) begin
        sum[k] = 0;
        lo[k]  = 0;
        hi[k]  = 0;
      end
      dropped = 0;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= root + b) begin
          n = n - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      return root;
    endfunction

    // fold one accepted vertex into the mesh, predict the result on last
    function void note_vertex(in_t v);
      int              p[3];
      int              cnt;
      longint          c[3];
      longint          diff;
      longint          ext[3];
      longint unsigned d;
      longint unsigned best;
      out_t            e;
      p[0] = v.pos_x;
      p[1] = v.pos_y;
      p[2] = v.pos_z;
      cnt = px.size();
      if (cnt < CAPACITY) begin
        for (int k = 0; k < 3; k++) begin
          if (cnt == 0 || p[k] < lo[k]) lo[k] = p[k];
          if (cnt == 0 || p[k] > hi[k]) hi[k] = p[k];
          sum[k] += p[k];
        end
        px = {px, p[0]};
        py = {py, p[1]};
        pz = {pz, p[2]};
      end else begin
        dropped = 1;
      end
      if (!v.last) return;
      cnt = px.size();
      for (int k = 0; k < 3; k++) begin
        c[k]   = sum[k] / longint'(cnt);
        ext[k] = longint'(hi[k]) - longint'(lo[k]);
      end
      // second pass: largest squared distance from the centroid
      best = 0;
      for (int i = 0; i < cnt; i++) begin
        d = 0;
        diff = longint'(px[i]) - c[0];
        if (diff < 0) diff = -diff;
        d += longint'(diff * diff);
        diff = longint'(py[i]) - c[1];
        if (diff < 0) diff = -diff;
        d += longint'(diff * diff);
        diff = longint'(pz[i]) - c[2];
        if (diff < 0) diff = -diff;
        d += longint'(diff * diff);
        if (d > best) best = d;
      end
      e.center_x = coord_t'(c[0]);
      e.center_y = coord_t'(c[1]);
      e.center_z = coord_t'(c[2]);
      e.half_x   = HALF_W'(ext[0] >> 1);
      e.half_y   = HALF_W'(ext[1] >> 1);
      e.half_z   = HALF_W'(ext[2] >> 1);
      e.radius   = RAD_W'(floor_sqrt(best));
      e.overflow = dropped;
      expected_q = {expected_q, e};
      clear_mesh();
    endfunction

    // compare one result with the oldest prediction
    function void check_result(out_t got);
      out_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: %h", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.center_x !== e.center_x || got.center_y !== e.center_y ||
          got.center_z !== e.center_z || got.half_x !== e.half_x ||
          got.half_y !== e.half_y || got.half_z !== e.half_z ||
          got.radius !== e.radius || got.overflow !== e.overflow) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp c=%0d,%0d,%0d h=%0d,%0d,%0d r=%0d ov=%0d",
                   e.center_x, e.center_y, e.center_z, e.half_x, e.half_y,
                   e.half_z, e.radius, e.overflow);
          $display("         got c=%0d,%0d,%0d h=%0d,%0d,%0d r=%0d ov=%0d",
                   got.center_x, got.center_y, got.center_z, got.half_x,
                   got.half_y, got.half_z, got.radius, got.overflow);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;

  bounds_scoreboard sb = new();
  int idle_pct = 0;
  int stall_cycles = 0;

  mesh_bounds_centroid_sphere_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // result monitor and watchdog on transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_data);
      if (out_valid || (start && !busy)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return coord_t'($urandom_range(0, 64)) - 32;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // one vertex transfer, with a random sender gap ahead of it
  task automatic send_vertex(coord_t x, coord_t y, coord_t z, logic last);
    in_t v;
    int  gap;
    v.pos_x = x;
    v.pos_y = y;
    v.pos_z = z;
    v.last  = last;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (busy);
    sb.note_vertex(v);
  endtask

  task automatic send_mesh(int n);
    for (int i = 0; i < n; i++)
      send_vertex(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single vertices at the extremes
    idle_pct = 16;
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    send_vertex(24'sd0, 24'sd0, 24'sd0, 1'b1);
    // widest extent on every axis
    send_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
    // negative sums truncate toward zero
    send_vertex(-24'sd3, -24'sd4, -24'sd5, 1'b0);
    send_vertex(24'sd0, 24'sd0, 24'sd0, 1'b1);
    send_vertex(24'sd1, -24'sd1, 24'sd2, 1'b0);
    send_vertex(24'sd0, 24'sd0, 24'sd0, 1'b0);
    send_vertex(24'sd0, 24'sd0, 24'sd1, 1'b1);
    // spread corners, worst-case radius
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);

    // random meshes, sender idling 16 then 71 percent
    for (int m = 0; m < 25; m++) send_mesh($urandom_range(1, 8));
    idle_pct = 71;
    for (int m = 0; m < 25; m++) send_mesh($urandom_range(1, 8));

    // no idling: a mesh past capacity with its last two vertices dropped
    idle_pct = 0;
    send_mesh(CAPACITY + 2);
    for (int m = 0; m < 10; m++) send_mesh($urandom_range(1, 8));
    start <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
